// ===== design/soa_pkg.sv =====
// Shared types and constants of the slab object allocator.
// Used by every module of the block; depends on nothing.
package soa_pkg;

   localparam int MAX_SLABS   = 64;
   localparam int MAX_OBJECTS = 512;

   localparam int ADDR_W   = 22;
   localparam int OSIZE_W  = 13;
   localparam int SBYTES_W = 17;
   localparam int CAP_W    = 10;
   localparam int CNT_W    = 10;
   localparam int DATA_W   = 32;
   localparam int PADDR_W  = 4;

   localparam int SLAB_W = $clog2(MAX_SLABS);
   localparam int SCNT_W = $clog2(MAX_SLABS + 1);
   localparam int OBJ_W  = $clog2(MAX_OBJECTS);
   localparam int SLOT_W = $clog2(MAX_SLABS * MAX_OBJECTS);

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(508);

   localparam logic [1:0] REG_OBJECT_SIZE   = 2'd0;
   localparam logic [1:0] REG_SLAB_BYTES    = 2'd1;
   localparam logic [1:0] REG_SLAB_CAPACITY = 2'd2;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FRAME = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] free_address;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] object_address;
      logic [1:0]        status;
   } rsp_item_type;

   typedef struct packed {
      logic              is_free;
      logic [ADDR_W-1:0] address;
   } cmd_type;

   typedef struct packed {
      logic [OSIZE_W-1:0]  object_size;
      logic [SBYTES_W-1:0] slab_bytes;
      logic [CAP_W-1:0]    slab_capacity;
   } cfg_type;

endpackage

// ===== design/soa_front.sv =====
// Front part: accepts request items, classifies them and queues commands.
// Depends on soa_pkg.
module soa_front import soa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_item_type req_item,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_take
);

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;
   cmd_type    classified;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      classified.is_free = req_item.opcode;
      classified.address = req_item.opcode ? req_item.free_address : '0;
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + (push_ok ? 2'd1 : 2'd0) - (pop_ok ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/soa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on soa_pkg.
module soa_div import soa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ADDR_W-1:0]   dividend,
   input  logic [SBYTES_W-1:0] divisor,
   output logic                busy,
   output logic                done,
   output logic [ADDR_W-1:0]   quotient,
   output logic [SBYTES_W-1:0] remainder
);

   localparam int STEP_W = $clog2(ADDR_W);

   logic [ADDR_W-1:0]   quot_ff, quot_in;
   logic [SBYTES_W-1:0] rem_ff, rem_in;
   logic [SBYTES_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SBYTES_W:0]   shifted;
   logic                fits;

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   always_comb begin
      shifted = {rem_ff, quot_ff[ADDR_W-1]};
      fits    = (shifted >= {1'b0, dvs_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         quot_in = {quot_ff[ADDR_W-2:0], fits};
         rem_in  = fits ? SBYTES_W'(shifted - {1'b0, dvs_ff}) : shifted[SBYTES_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

endmodule

// ===== design/soa_back.sv =====
// Back part: sequencer over the slab list, per-slab memories and object stacks.
// Depends on soa_pkg and soa_div.
module soa_back import soa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cfg_wr,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_take,
   input  logic         res_room,
   output logic         res_push,
   output rsp_item_type res_item
);

   typedef enum logic [3:0] {
      S_IDLE, S_CAPDIV, S_AHEAD, S_ASLAB, S_NEW, S_POP, S_LINK, S_MARK,
      S_ADDR, S_FDIV1, S_FDIV2, S_FCHK
   } state_type;

   localparam int PS_W = SLAB_W + SBYTES_W;
   localparam int PI_W = OBJ_W + OSIZE_W;
   localparam int SUM_W = (PS_W > PI_W ? PS_W : PI_W) + 1;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLAB_W-1:0] s,
                                                  input logic [OBJ_W-1:0]  i);
      slot_of = SLOT_W'(SLOT_W'(s) * SLOT_W'(MAX_OBJECTS)) + SLOT_W'(i);
   endfunction

   state_type             state_ff, state_in;
   logic [SLAB_W-1:0]     order_head_ff, order_head_in;
   logic [SCNT_W-1:0]     slab_count_ff, slab_count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  dirty_ff, dirty_in;
   logic [SLAB_W-1:0]     s_ff, s_in;
   logic [CNT_W-1:0]      fc_ff, fc_in;
   logic [OBJ_W-1:0]      top_ff, top_in;
   logic [CNT_W-1:0]      wm_ff, wm_in;
   logic [OBJ_W-1:0]      idx_ff, idx_in;
   logic [PS_W-1:0]       prod_s_ff, prod_s_in;
   logic [PI_W-1:0]       prod_i_ff, prod_i_in;

   logic [SLAB_W-1:0]     order_mem [MAX_SLABS];
   logic [CNT_W-1:0]      fcnt_mem [MAX_SLABS];
   logic [OBJ_W-1:0]      top_mem [MAX_SLABS];
   logic [CNT_W-1:0]      wm_mem [MAX_SLABS];
   logic [MAX_OBJECTS-1:0] flag_mem [MAX_SLABS];
   logic [OBJ_W-1:0]      link_mem [MAX_SLABS * MAX_OBJECTS];

   logic [SLAB_W-1:0]     order_rd_ff;
   logic [CNT_W-1:0]      fc_rd_ff;
   logic [OBJ_W-1:0]      top_rd_ff;
   logic [CNT_W-1:0]      wm_rd_ff;
   logic [MAX_OBJECTS-1:0] flag_rd_ff;
   logic [OBJ_W-1:0]      link_rd_ff;

   logic                  order_we;
   logic [SLAB_W-1:0]     order_waddr;
   logic [SLAB_W-1:0]     order_wdata;
   logic [SLAB_W-1:0]     slab_raddr;
   logic                  slab_we;
   logic [CNT_W-1:0]      fc_wdata;
   logic [OBJ_W-1:0]      top_wdata;
   logic [CNT_W-1:0]      wm_wdata;
   logic                  flag_we;
   logic [SLAB_W-1:0]     flag_waddr;
   logic [MAX_OBJECTS-1:0] flag_wdata;
   logic                  link_we;
   logic [SLOT_W-1:0]     link_waddr;
   logic [SLOT_W-1:0]     link_raddr;

   logic                  div_start;
   logic [ADDR_W-1:0]     div_dividend;
   logic [SBYTES_W-1:0]   div_divisor;
   logic                  div_busy;
   logic                  div_done;
   logic [ADDR_W-1:0]     div_quot;
   logic [SBYTES_W-1:0]   div_rem;

   logic [OSIZE_W-1:0]    os_eff;
   logic [SBYTES_W-1:0]   sb_eff;
   logic [CNT_W-1:0]      fresh_left;
   logic [CNT_W-1:0]      fc_dec;
   logic [SCNT_W:0]       tail_sum;
   logic [SLAB_W-1:0]     tail;
   logic [SLAB_W-1:0]     head_dec;
   logic [SLAB_W-1:0]     head_inc;
   logic [ADDR_W-1:0]     cap_lim;
   logic [ADDR_W-1:0]     cap_fit;
   logic [SUM_W-1:0]      addr_sum;

   soa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign os_eff = (cfg.object_size == '0) ? OSIZE_W'(1) : cfg.object_size;
   assign sb_eff = (cfg.slab_bytes == '0) ? SBYTES_W'(1) : cfg.slab_bytes;

   always_comb begin
      fresh_left = (wm_ff < cap_ff) ? CNT_W'(cap_ff - wm_ff) : '0;
      fc_dec     = fc_ff - CNT_W'(1);
      tail_sum   = (SCNT_W+1)'(order_head_ff) + (SCNT_W+1)'(slab_count_ff);
      tail       = (tail_sum >= (SCNT_W+1)'(MAX_SLABS))
                   ? SLAB_W'(tail_sum - (SCNT_W+1)'(MAX_SLABS)) : SLAB_W'(tail_sum);
      head_dec   = (order_head_ff == '0) ? SLAB_W'(MAX_SLABS - 1)
                   : order_head_ff - SLAB_W'(1);
      head_inc   = (order_head_ff == SLAB_W'(MAX_SLABS - 1)) ? '0
                   : order_head_ff + SLAB_W'(1);
      cap_lim    = (ADDR_W'(cfg.slab_capacity) > ADDR_W'(MAX_OBJECTS))
                   ? ADDR_W'(MAX_OBJECTS) : ADDR_W'(cfg.slab_capacity);
      cap_fit    = (cap_lim > div_quot) ? div_quot : cap_lim;
      addr_sum   = SUM_W'(prod_s_ff) + SUM_W'(prod_i_ff);
      link_raddr = slot_of(s_ff, top_ff);
      slab_raddr = (state_ff == S_AHEAD) ? order_rd_ff : s_ff;
   end

   always_comb begin
      state_in      = state_ff;
      order_head_in = order_head_ff;
      slab_count_in = slab_count_ff;
      cap_in        = cap_ff;
      dirty_in      = dirty_ff;
      s_in          = s_ff;
      fc_in         = fc_ff;
      top_in        = top_ff;
      wm_in         = wm_ff;
      idx_in        = idx_ff;
      prod_s_in     = prod_s_ff;
      prod_i_in     = prod_i_ff;
      cmd_take      = 1'b0;
      res_push      = 1'b0;
      res_item      = '{object_address: '0, status: ST_BAD_FREE};
      div_start     = 1'b0;
      div_dividend  = ADDR_W'(sb_eff);
      div_divisor   = SBYTES_W'(os_eff);
      order_we      = 1'b0;
      order_waddr   = head_dec;
      order_wdata   = s_ff;
      slab_we       = 1'b0;
      fc_wdata      = fc_dec;
      top_wdata     = top_ff;
      wm_wdata      = wm_ff;
      flag_we       = 1'b0;
      flag_waddr    = s_ff;
      flag_wdata    = flag_rd_ff | (MAX_OBJECTS'(1) << idx_ff);
      link_we       = 1'b0;
      link_waddr    = slot_of(s_ff, idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (dirty_ff) begin
               div_start = 1'b1;
               dirty_in  = 1'b0;
               state_in  = S_CAPDIV;
            end else if (cmd_valid && res_room) begin
               cmd_take = 1'b1;
               if (cmd.is_free) begin
                  div_start    = 1'b1;
                  div_dividend = cmd.address;
                  div_divisor  = sb_eff;
                  state_in     = S_FDIV1;
               end else if (slab_count_ff == '0) begin
                  state_in = S_NEW;
               end else begin
                  state_in = S_AHEAD;
               end
            end
         end
         S_CAPDIV: begin
            if (div_done) begin
               cap_in   = (cap_fit == '0) ? CAP_W'(1) : CAP_W'(cap_fit);
               state_in = S_IDLE;
            end
         end
         S_AHEAD: begin
            s_in     = order_rd_ff;
            state_in = S_ASLAB;
         end
         S_ASLAB: begin
            fc_in    = fc_rd_ff;
            top_in   = top_rd_ff;
            wm_in    = wm_rd_ff;
            state_in = (fc_rd_ff == '0) ? S_NEW : S_POP;
         end
         S_NEW: begin
            if (slab_count_ff >= SCNT_W'(MAX_SLABS)) begin
               res_push = 1'b1;
               res_item = '{object_address: '0, status: ST_NO_FRAME};
               state_in = S_IDLE;
            end else begin
               order_we      = 1'b1;
               order_waddr   = head_dec;
               order_wdata   = SLAB_W'(slab_count_ff);
               order_head_in = head_dec;
               slab_count_in = slab_count_ff + SCNT_W'(1);
               s_in          = SLAB_W'(slab_count_ff);
               fc_in         = CNT_W'(cap_ff);
               top_in        = '0;
               wm_in         = '0;
               flag_we       = 1'b1;
               flag_waddr    = SLAB_W'(slab_count_ff);
               flag_wdata    = '0;
               state_in      = S_POP;
            end
         end
         S_POP: begin
            if (fc_ff > fresh_left) begin
               idx_in   = top_ff;
               state_in = S_LINK;
            end else begin
               idx_in   = OBJ_W'(wm_ff);
               wm_in    = wm_ff + CNT_W'(1);
               state_in = S_MARK;
            end
         end
         S_LINK: begin
            top_in   = link_rd_ff;
            state_in = S_MARK;
         end
         S_MARK: begin
            flag_we   = 1'b1;
            slab_we   = 1'b1;
            fc_wdata  = fc_dec;
            top_wdata = top_ff;
            wm_wdata  = wm_ff;
            fc_in     = fc_dec;
            if (fc_dec == '0) begin
               order_we      = 1'b1;
               order_waddr   = tail;
               order_wdata   = s_ff;
               order_head_in = head_inc;
            end
            prod_s_in = PS_W'(s_ff) * PS_W'(sb_eff);
            prod_i_in = PI_W'(idx_ff) * PI_W'(os_eff);
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            res_push = 1'b1;
            res_item = '{object_address: ADDR_W'(addr_sum), status: ST_OK};
            state_in = S_IDLE;
         end
         S_FDIV1: begin
            if (div_done) begin
               if (div_quot >= ADDR_W'(slab_count_ff)) begin
                  res_push = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  s_in         = SLAB_W'(div_quot);
                  div_start    = 1'b1;
                  div_dividend = ADDR_W'(div_rem);
                  div_divisor  = SBYTES_W'(os_eff);
                  state_in     = S_FDIV2;
               end
            end
         end
         S_FDIV2: begin
            if (div_done) begin
               if (div_rem != '0 || div_quot >= ADDR_W'(cap_ff)) begin
                  res_push = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = OBJ_W'(div_quot);
                  state_in = S_FCHK;
               end
            end
         end
         S_FCHK: begin
            res_push = 1'b1;
            state_in = S_IDLE;
            if (flag_rd_ff[idx_ff]) begin
               res_item   = '{object_address: '0, status: ST_OK};
               flag_we    = 1'b1;
               flag_wdata = flag_rd_ff & ~(MAX_OBJECTS'(1) << idx_ff);
               link_we    = 1'b1;
               link_waddr = slot_of(s_ff, idx_ff);
               slab_we    = 1'b1;
               fc_wdata   = (fc_rd_ff < COUNT_MAX) ? fc_rd_ff + CNT_W'(1) : fc_rd_ff;
               top_wdata  = idx_ff;
               wm_wdata   = wm_rd_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_head_ff];
   end

   always_ff @(posedge clock) begin
      if (slab_we) begin
         fcnt_mem[s_ff] <= fc_wdata;
         top_mem[s_ff]  <= top_wdata;
         wm_mem[s_ff]   <= wm_wdata;
      end
      fc_rd_ff  <= fcnt_mem[slab_raddr];
      top_rd_ff <= top_mem[slab_raddr];
      wm_rd_ff  <= wm_mem[slab_raddr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_waddr] <= flag_wdata;
      end
      flag_rd_ff <= flag_mem[s_ff];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= top_rd_ff;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         order_head_ff <= '0;
         slab_count_ff <= '0;
         cap_ff        <= CAP_RESET;
         dirty_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         order_head_ff <= order_head_in;
         slab_count_ff <= slab_count_in;
         cap_ff        <= cap_in;
         dirty_ff      <= dirty_in;
      end
      s_ff      <= s_in;
      fc_ff     <= fc_in;
      top_ff    <= top_in;
      wm_ff     <= wm_in;
      idx_ff    <= idx_in;
      prod_s_ff <= prod_s_in;
      prod_i_ff <= prod_i_in;
   end

endmodule

// ===== design/slab_object_allocator_core.sv =====
// Top level: configuration registers, front and back parts, result queue.
// Depends on soa_pkg, soa_front and soa_back.
// The block works on one item at a time. An allocate runs the sequencer steps list
// head read and slab record read (skipped while no frame is taken), optional new
// frame, optional stack link read and address multiply. A free makes two passes of
// the shared bit-serial divider that split the address into slab and object index;
// the second runs only for a taken slab. After any configuration write the first
// item waits while the same divider recomputes the usable slab capacity. Two-entry
// queues on the input and result sides absorb stalls of either neighbor, though a
// full result queue stops commands being taken. Allocation flags of a slab are
// cleared when its frame is taken, so no clearing pass follows reset.
module slab_object_allocator_core import soa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  req_item_type        req_item,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_item_type        rsp_item,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [PADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   cfg_type      cfg_ff, cfg_in;
   logic         cfg_wr;
   logic [1:0]   reg_index;
   logic         cmd_valid;
   cmd_type      cmd;
   logic         cmd_take;
   logic         res_push;
   rsp_item_type res_item;
   logic         res_room;

   rsp_item_type rq_ff [2];
   logic         rq_wr_ff, rq_wr_in;
   logic         rq_rd_ff, rq_rd_in;
   logic [1:0]   rq_count_ff, rq_count_in;
   logic         rq_pop;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_index)
            REG_OBJECT_SIZE:   cfg_in.object_size   = csr_pwdata[OSIZE_W-1:0];
            REG_SLAB_BYTES:    cfg_in.slab_bytes    = csr_pwdata[SBYTES_W-1:0];
            REG_SLAB_CAPACITY: cfg_in.slab_capacity = csr_pwdata[CAP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
      case (reg_index)
         REG_OBJECT_SIZE:   csr_prdata = DATA_W'(cfg_ff.object_size);
         REG_SLAB_BYTES:    csr_prdata = DATA_W'(cfg_ff.slab_bytes);
         REG_SLAB_CAPACITY: csr_prdata = DATA_W'(cfg_ff.slab_capacity);
         default:           csr_prdata = '0;
      endcase
   end

   soa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   soa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_wr    (cfg_wr),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .res_room  (res_room),
      .res_push  (res_push),
      .res_item  (res_item)
   );

   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp_item  = rq_ff[rq_rd_ff];
   assign res_room  = (rq_count_ff != 2'd2);
   assign rq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      rq_wr_in    = res_push ? ~rq_wr_ff : rq_wr_ff;
      rq_rd_in    = rq_pop ? ~rq_rd_ff : rq_rd_ff;
      rq_count_in = rq_count_ff + (res_push ? 2'd1 : 2'd0) - (rq_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.object_size   <= OSIZE_W'(8);
         cfg_ff.slab_bytes    <= SBYTES_W'(4096);
         cfg_ff.slab_capacity <= CAP_RESET;
         rq_wr_ff             <= 1'b0;
         rq_rd_ff             <= 1'b0;
         rq_count_ff          <= 2'd0;
      end else begin
         cfg_ff      <= cfg_in;
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for slab_object_allocator_core: mixed allocate/free traffic over
// several zone geometries, checked against an in-bench slab list and object stack model.
// Depends on soa_pkg and the core's RTL only.
`timescale 1ns / 100ps

module tb_top;
   import soa_pkg::*;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   req_item_type       req_item = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   rsp_item_type       rsp_item;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0]  csr_pwdata = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   slab_object_allocator_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // zone model
   logic [OSIZE_W-1:0]  zone_osize = 8;
   logic [SBYTES_W-1:0] zone_sbytes = 4096;
   logic [CAP_W-1:0]    zone_cap = CAP_RESET;
   int unsigned slab_list[MAX_SLABS];
   int unsigned list_head = 0;
   int unsigned frames_taken = 0;
   int unsigned free_cnt[MAX_SLABS];
   int unsigned stack_top[MAX_SLABS];
   int unsigned watermark[MAX_SLABS];
   int unsigned link_mem[MAX_SLABS*MAX_OBJECTS];
   bit          link_valid[MAX_SLABS*MAX_OBJECTS];
   bit          in_use[MAX_SLABS*MAX_OBJECTS];

   rsp_item_type      expected_q[$];
   logic [ADDR_W-1:0] live_q[$];
   logic [ADDR_W-1:0] last_freed = '0;
   int errors = 0;
   int checked = 0;
   int sent = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_request = 0;
   int hold_left = 0;

   function automatic int unsigned osize_eff();
      return (zone_osize == 0) ? 1 : zone_osize;
   endfunction

   function automatic int unsigned sbytes_eff();
      return (zone_sbytes == 0) ? 1 : zone_sbytes;
   endfunction

   function automatic int unsigned usable_cap();
      int unsigned c;
      int unsigned fit;
      c = zone_cap;
      fit = sbytes_eff() / osize_eff();
      if (c > MAX_OBJECTS) c = MAX_OBJECTS;
      if (c > fit) c = fit;
      if (c == 0) c = 1;
      return c;
   endfunction

   function automatic bit alloc_reads_stale();
      int unsigned s;
      int unsigned fresh;
      if (frames_taken == 0 || free_cnt[slab_list[list_head]] == 0) return 0;
      s = slab_list[list_head];
      fresh = (watermark[s] < usable_cap()) ? usable_cap() - watermark[s] : 0;
      if (free_cnt[s] > fresh)
         return !link_valid[s*MAX_OBJECTS + stack_top[s] % MAX_OBJECTS];
      return 0;
   endfunction

   function automatic rsp_item_type predict_alloc();
      rsp_item_type r;
      int unsigned cap;
      int unsigned s;
      int unsigned idx;
      int unsigned fresh;
      logic [63:0] a;
      cap = usable_cap();
      r = '0;
      if (frames_taken == 0 || free_cnt[slab_list[list_head]] == 0) begin
         if (frames_taken >= MAX_SLABS) begin
            r.status = ST_NO_FRAME;
            return r;
         end
         s = frames_taken;
         list_head = (list_head == 0) ? MAX_SLABS - 1 : list_head - 1;
         slab_list[list_head] = s;
         frames_taken++;
         free_cnt[s] = cap;
         stack_top[s] = 0;
         watermark[s] = 0;
      end
      s = slab_list[list_head];
      fresh = (watermark[s] < cap) ? cap - watermark[s] : 0;
      if (free_cnt[s] > fresh) begin
         idx = stack_top[s] % MAX_OBJECTS;
         stack_top[s] = link_mem[s*MAX_OBJECTS + idx] % MAX_OBJECTS;
      end else begin
         idx = watermark[s] % MAX_OBJECTS;
         watermark[s]++;
      end
      in_use[s*MAX_OBJECTS + idx] = 1;
      free_cnt[s]--;
      if (free_cnt[s] == 0) begin
         slab_list[(list_head + frames_taken) % MAX_SLABS] = s;
         list_head = (list_head + 1) % MAX_SLABS;
      end
      a = 64'(s) * sbytes_eff() + 64'(idx) * osize_eff();
      r.object_address = a[ADDR_W-1:0];
      r.status = ST_OK;
      live_q.push_back(r.object_address);
      return r;
   endfunction

   function automatic rsp_item_type predict_free(logic [ADDR_W-1:0] a);
      rsp_item_type r;
      int unsigned s;
      int unsigned off;
      int unsigned idx;
      int unsigned slot;
      int hits[$];
      r = '0;
      r.status = ST_BAD_FREE;
      s = a / sbytes_eff();
      off = a % sbytes_eff();
      if (s >= frames_taken || s >= MAX_SLABS) return r;
      if (off % osize_eff() != 0) return r;
      idx = off / osize_eff();
      if (idx >= usable_cap() || idx >= MAX_OBJECTS) return r;
      slot = s*MAX_OBJECTS + idx;
      if (!in_use[slot]) return r;
      in_use[slot] = 0;
      link_mem[slot] = stack_top[s];
      link_valid[slot] = 1;
      stack_top[s] = idx;
      if (free_cnt[s] < COUNT_MAX) free_cnt[s]++;
      r.status = ST_OK;
      last_freed = a;
      hits = live_q.find_first_index(x) with (x == a);
      if (hits.size() > 0) live_q.delete(hits[0]);
      return r;
   endfunction

   task automatic send_item(input logic op, input logic [ADDR_W-1:0] a);
      req_item_type it;
      it.opcode = op;
      it.free_address = (op == OP_ALLOC) ? ADDR_W'($urandom) : a;
      expected_q.push_back((op == OP_FREE) ? predict_free(a) : predict_alloc());
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_random_op();
      int pick;
      int alloc_pct;
      pick = $urandom_range(99);
      alloc_pct = (frames_taken < 48) ? 55 : 15;
      if (pick < alloc_pct && !alloc_reads_stale())
         send_item(OP_ALLOC, '0);
      else if (live_q.size() > 0 && pick < 90)
         send_item(OP_FREE, live_q[$urandom_range(live_q.size()-1)]);
      else if (pick < 95)
         send_item(OP_FREE, last_freed);
      else
         send_item(OP_FREE, ADDR_W'($urandom));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= PADDR_W'({idx, 2'b00});
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_OBJECT_SIZE: begin
            zone_osize = v[OSIZE_W-1:0];
         end
         REG_SLAB_BYTES: begin
            zone_sbytes = v[SBYTES_W-1:0];
         end
         default: begin
            zone_cap = v[CAP_W-1:0];
         end
      endcase
   endtask

   task automatic set_geometry(input int unsigned os, input int unsigned sb,
                               input int unsigned cap);
      write_reg(REG_OBJECT_SIZE, os);
      write_reg(REG_SLAB_BYTES, sb);
      write_reg(REG_SLAB_CAPACITY, cap);
   endtask

   task automatic test_directed();
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_FREE, 22'd8);
      send_item(OP_FREE, 22'd8);
      send_item(OP_FREE, 22'd3);
      send_item(OP_FREE, 22'd20480);
      send_item(OP_FREE, 22'h3FFFFF);
      send_item(OP_FREE, 22'd4064);
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_FREE, 22'd0);
      send_item(OP_FREE, 22'd0);
      send_item(OP_ALLOC, '0);
      drain();
   endtask

   task automatic run_phase(input int unsigned os, input int unsigned sb, input int unsigned cap,
                            input int idle_pct, input int stall_pct, input int n);
      set_geometry(os, sb, cap);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) send_random_op();
      drain();
   endtask

   task automatic test_traffic();
      run_phase(8, 4096, 508, 0, 0, 300);
      run_phase(4096, 65536, 16, 87, 0, 200);
      run_phase(8, 65536, 512, 0, 87, 300);
      run_phase(24, 4096, 170, 28, 28, 300);
      run_phase(8191, 131071, 1023, 0, 0, 150);
      run_phase(100, 8192, 81, 28, 28, 250);
      run_phase(16, 4096, 508, 0, 0, 300);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 1;
      repeat (60) send_random_op();
      drain();
   endtask

   task automatic test_frame_exhaustion();
      int tries;
      set_geometry(0, 0, 1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      tries = 0;
      while (frames_taken < MAX_SLABS && tries < 400) begin
         if (alloc_reads_stale() && live_q.size() > 0)
            send_item(OP_FREE, live_q[0]);
         else if (!alloc_reads_stale())
            send_item(OP_ALLOC, '0);
         tries++;
      end
      repeat (6) begin
         if (!alloc_reads_stale()) send_item(OP_ALLOC, '0);
      end
      send_item(OP_FREE, 22'd70);
      drain();
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result addr=%h status=%0d", $time,
                  got.object_address, got.status);
         errors++;
      end else begin
         want = expected_q.pop_front();
         checked++;
         if (got.object_address !== want.object_address) begin
            $display("%0t: object_address expected %h actual %h", $time,
                     want.object_address, got.object_address);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_item);
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_traffic();
      test_backpressure();
      test_frame_exhaustion();
      repeat (100) @(posedge clock);
      $display("Sent %0d items and checked %0d results across 8 zone geometries,", sent, checked);
      $display("idle/stall mixes, a long result hold-off and slab frame exhaustion.");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== slab_object_allocator_core.f =====
design/soa_pkg.sv
design/soa_front.sv
design/soa_div.sv
design/soa_back.sv
design/slab_object_allocator_core.sv
tb/sv/tb_top.sv
